>>> sv/lfx_pkg.sv
// ----------------------------------------------------------------------------
// lfx_pkg
// Shared types and constants for the lagged-Fibonacci XOR random word source.
// ----------------------------------------------------------------------------
package lfx_pkg;

	localparam int WORD_W = 32;
	localparam int IDX_W  = 8;

	// Lags behind the write pointer
	localparam int LAG_SHORT = 24;
	localparam int LAG_LONG  = 55;
	localparam int LAG_OUT   = 61;

	typedef enum logic {
		CMD_GENERATE = 1'b0,
		CMD_LOAD     = 1'b1
	} cmd_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage

>>> sv/lagged_fibonacci_xor_rng.sv
// ----------------------------------------------------------------------------
// lagged_fibonacci_xor_rng
// Lagged-Fibonacci random word source with lags 24 and 55 and an XOR tap at 61.
// ----------------------------------------------------------------------------
// The table lives in a ring of TABLE_DEPTH word cells; cell k holds the entry
// at k places past the write pointer, so the three lag taps sit at fixed cells
// and each generate beat shifts the whole ring by one while the new sum enters
// at the far end. The block takes one generate beat per clock as long as the
// two-entry output buffer has room and no ring rotation is under way. A load
// beat writes its seed; if the write pointer was not zero it is followed by a
// ring rotation of (TABLE_DEPTH - pointer) places, with item_ready low, that
// realigns the ring to a pointer of zero. A load right after a load needs no
// rotation. Reads of table entries that were never seeded return arbitrary data.
// ----------------------------------------------------------------------------
module lagged_fibonacci_xor_rng #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic                           command,
	input  logic [lfx_pkg::IDX_W-1:0]      seed_index,
	input  logic [lfx_pkg::WORD_W-1:0]     seed_value,
	output logic                           word_valid,
	input  logic                           word_ready,
	output logic [lfx_pkg::WORD_W-1:0]     random_word
);

	localparam int AW        = $clog2(TABLE_DEPTH);
	localparam int XW        = AW + lfx_pkg::IDX_W;
	localparam int TAP_SHORT = TABLE_DEPTH - lfx_pkg::LAG_SHORT;
	localparam int TAP_LONG  = TABLE_DEPTH - lfx_pkg::LAG_LONG;
	localparam int TAP_OUT   = TABLE_DEPTH - lfx_pkg::LAG_OUT;
	localparam logic [AW-1:0] P_LAST  = AW'(TABLE_DEPTH - 1);
	localparam logic [AW:0]   DEPTH_V = (AW+1)'(TABLE_DEPTH);
	localparam logic [XW-1:0] DEPTH_X = XW'(TABLE_DEPTH);

	logic [AW-1:0]              p_q;
	logic [AW-1:0]              rot_q;
	logic                       rot_busy;
	logic                       obuf_full;
	logic                       item_fire;
	logic                       gen_fire;
	logic                       load_fire;
	logic                       shift_en;
	logic [lfx_pkg::WORD_W-1:0] cell_word [TABLE_DEPTH];
	lfx_pkg::cell_ctrl_t        cell_ctrl [TABLE_DEPTH];
	logic [lfx_pkg::WORD_W-1:0] sum_word;
	logic [lfx_pkg::WORD_W-1:0] gen_word;
	logic [lfx_pkg::WORD_W-1:0] last_in;
	logic [XW-1:0]              idx_red;
	logic [XW-1:0]              phys_x;
	logic [AW-1:0]              phys_idx;
	logic [AW:0]                rot_span;

	assign rot_busy   = (rot_q != '0);
	assign item_ready = !rot_busy && !obuf_full;
	assign item_fire  = item_valid && item_ready;
	assign gen_fire   = item_fire && (command == lfx_pkg::CMD_GENERATE);
	assign load_fire  = item_fire && (command == lfx_pkg::CMD_LOAD);
	assign shift_en   = gen_fire || rot_busy;

	// Lag taps sit at fixed cells of the ring
	assign sum_word = cell_word[TAP_SHORT] + cell_word[TAP_LONG];
	assign gen_word = sum_word ^ cell_word[TAP_OUT];
	// New sum enters at the tail on generate; the head wraps around on rotate
	assign last_in  = rot_busy ? cell_word[0] : sum_word;

	// Map the seed index onto its cell: (index mod depth - pointer) mod depth
	always_comb begin
		idx_red = XW'(seed_index);
		for (int i = 0; i < 3; i++) begin
			if (idx_red >= DEPTH_X) begin
				idx_red = idx_red - DEPTH_X;
			end
		end
		phys_x = idx_red + DEPTH_X - XW'(p_q);
		if (phys_x >= DEPTH_X) begin
			phys_x = phys_x - DEPTH_X;
		end
		phys_idx = phys_x[AW-1:0];
	end

	assign rot_span = DEPTH_V - {1'b0, p_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q   <= '0;
			rot_q <= '0;
		end else if (load_fire) begin
			p_q   <= '0;
			rot_q <= (p_q == '0) ? '0 : rot_span[AW-1:0];
		end else if (rot_busy) begin
			rot_q <= rot_q - 1'b1;
		end else if (gen_fire) begin
			p_q <= (p_q == P_LAST) ? '0 : p_q + 1'b1;
		end
	end

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		assign cell_ctrl[k] = '{shift: shift_en, load: load_fire && (phys_idx == AW'(k))};
		if (k == TABLE_DEPTH - 1) begin : g_tail
			lfx_cell u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl[k]),
				.shift_in   (last_in),
				.load_value (seed_value),
				.word       (cell_word[k])
			);
		end else begin : g_body
			lfx_cell u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl[k]),
				.shift_in   (cell_word[k+1]),
				.load_value (seed_value),
				.word       (cell_word[k])
			);
		end
	end

	lfx_obuf u_obuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (gen_fire),
		.push_data   (gen_word),
		.full        (obuf_full),
		.word_valid  (word_valid),
		.word_ready  (word_ready),
		.random_word (random_word)
	);

	// A load always leaves the pointer at zero
	a_load_clears_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		load_fire |=> (p_q == '0))
		else $error("pointer not cleared after load");

	// Rotation counts down one per clock and nothing interrupts it
	a_rot_countdown: assert property (@(posedge clk) disable iff (!arst_n)
		rot_busy |=> (rot_q == $past(rot_q) - 1'b1))
		else $error("ring rotation count skipped");

	// Skid entry only holds a beat while the head is occupied
	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		obuf_full |-> word_valid)
		else $error("skid entry valid with empty head");

	// No generate beat may shift the ring mid-rotation
	a_no_gen_in_rot: assert property (@(posedge clk) disable iff (!arst_n)
		rot_busy |-> !gen_fire)
		else $error("generate accepted during ring rotation");

endmodule

>>> sv/lfx_cell.sv
// ----------------------------------------------------------------------------
// lfx_cell
// One word of the lag ring: takes its neighbor's word on a shift, or a seed
// word on a load.
// ----------------------------------------------------------------------------
module lfx_cell (
	input  logic                           clk,
	input  lfx_pkg::cell_ctrl_t            ctrl,
	input  logic [lfx_pkg::WORD_W-1:0]     shift_in,
	input  logic [lfx_pkg::WORD_W-1:0]     load_value,
	output logic [lfx_pkg::WORD_W-1:0]     word
);

	logic [lfx_pkg::WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			word_q <= load_value;
		end else if (ctrl.shift) begin
			word_q <= shift_in;
		end
	end

	assign word = word_q;

endmodule

>>> sv/lfx_obuf.sv
// ----------------------------------------------------------------------------
// lfx_obuf
// Two-entry output buffer: a head register that drives the port and a skid
// register that catches a beat while the head is stalled.
// ----------------------------------------------------------------------------
module lfx_obuf (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [lfx_pkg::WORD_W-1:0]     push_data,
	output logic                           full,
	output logic                           word_valid,
	input  logic                           word_ready,
	output logic [lfx_pkg::WORD_W-1:0]     random_word
);

	logic                       head_valid_q;
	logic                       skid_valid_q;
	logic [lfx_pkg::WORD_W-1:0] head_q;
	logic [lfx_pkg::WORD_W-1:0] skid_q;
	logic                       head_free;

	assign head_free = !head_valid_q || word_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (head_free) begin
			if (skid_valid_q) begin
				head_valid_q <= 1'b1;
				skid_valid_q <= push;
			end else begin
				head_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (head_free) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
				skid_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign full        = skid_valid_q;
	assign word_valid  = head_valid_q;
	assign random_word = head_q;

endmodule
